>>> rtl/bda_pkg.sv
package bda_pkg;

  localparam int PIX_W          = 8;
  localparam int OUT_X_W        = 8;
  localparam int OUT_Y_W        = 12;
  localparam int LANES          = 4;
  localparam int MAX_OUT_HEIGHT = 4096;
  localparam int ORW            = $clog2(MAX_OUT_HEIGHT + 1);

  localparam int CFG_SW_W   = 13;
  localparam int CFG_OW_W   = 9;
  localparam int CFG_OH_W   = 13;
  localparam int CFG_BLK_W  = 5;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_H    = 3'd4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } bda_state_e;

endpackage

>>> rtl/bda_pix_if.sv
interface bda_pix_if import bda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;
  logic             frame_start;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_start,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, frame_start,
                output ready);
endinterface

>>> rtl/bda_avg_if.sv
interface bda_avg_if import bda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   red_avg;
  logic [PIX_W-1:0]   green_avg;
  logic [PIX_W-1:0]   blue_avg;
  logic [PIX_W-1:0]   alpha_avg;
  logic [OUT_X_W-1:0] out_x;
  logic [OUT_Y_W-1:0] out_y;
  logic               frame_done;

  modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, out_x, out_y,
                  frame_done, input ready);
  modport sink (input valid, red_avg, green_avg, blue_avg, alpha_avg, out_x, out_y,
                frame_done, output ready);
endinterface

>>> rtl/bda_div.sv
module bda_div import bda_pkg::*; #(
  parameter int SUMW = 16,
  parameter int NW   = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [LANES-1:0][SUMW-1:0]  dividend_i,
  input  logic [NW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [LANES-1:0][SUMW-1:0]  quot_o
);

  localparam int CW = $clog2(SUMW + 1);

  logic [CW-1:0]                cnt_q;
  logic [NW-1:0]                div_q;
  logic [LANES-1:0][SUMW-1:0]   quo_q, quo_d;
  logic [LANES-1:0][NW-1:0]     rem_q, rem_d;
  logic [NW:0]                  trial;

  // one quotient bit per lane per cycle, restoring
  always_comb begin
    trial = '0;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_q[l], quo_q[l][SUMW-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d[l] = NW'(trial - {1'b0, div_q});
        quo_d[l] = {quo_q[l][SUMW-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[NW-1:0];
        quo_d[l] = {quo_q[l][SUMW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(SUMW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

>>> rtl/box_downscale_average_unit.sv
// a source pixel outside the output grid is taken straight from idle, one inside it
// adds the update state (column sum read from the sum memory, then add and write back)
// a pixel that completes a block adds the one-bit-per-cycle divider, which must finish
// before the next pixel is accepted
// the result sits in an output register; a stalled sink stalls only a block-completing pixel
// reset clears counters and control, sets all config registers to 1; the sum memory is not cleared
module box_downscale_average_unit import bda_pkg::*; #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int MAX_BLOCK     = 16,
  parameter int MAX_SRC_WIDTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bda_pix_if.sink               pix_i,
  bda_avg_if.source             avg_o
);

  localparam int SCW  = $clog2(MAX_SRC_WIDTH + 1);
  localparam int OCW  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int AW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int BKW  = $clog2(MAX_BLOCK + 1);
  localparam int NW   = 2 * BKW;
  localparam int SUMW = PIX_W + $clog2(MAX_BLOCK * MAX_BLOCK);

  // configuration
  logic [CFG_SW_W-1:0]  src_width_q;
  logic [CFG_OW_W-1:0]  out_width_q;
  logic [CFG_OH_W-1:0]  out_height_q;
  logic [CFG_BLK_W-1:0] block_w_q, block_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= CFG_SW_W'(1);
      out_width_q  <= CFG_OW_W'(1);
      out_height_q <= CFG_OH_W'(1);
      block_w_q    <= CFG_BLK_W'(1);
      block_h_q    <= CFG_BLK_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[CFG_SW_W-1:0];
        CFG_OUT_WIDTH:  out_width_q  <= cfg_wdata_i[CFG_OW_W-1:0];
        CFG_OUT_HEIGHT: out_height_q <= cfg_wdata_i[CFG_OH_W-1:0];
        CFG_BLOCK_W:    block_w_q    <= cfg_wdata_i[CFG_BLK_W-1:0];
        CFG_BLOCK_H:    block_h_q    <= cfg_wdata_i[CFG_BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped limits
  logic [SCW-1:0] sw_c;
  logic [OCW-1:0] ow_c;
  logic [ORW-1:0] oh_c;
  logic [BKW-1:0] bw_c, bh_c;

  always_comb begin
    if (src_width_q == '0) sw_c = SCW'(1);
    else if (int'(src_width_q) > MAX_SRC_WIDTH) sw_c = SCW'(MAX_SRC_WIDTH);
    else sw_c = SCW'(src_width_q);

    if (out_width_q == '0) ow_c = OCW'(1);
    else if (int'(out_width_q) > MAX_OUT_WIDTH) ow_c = OCW'(MAX_OUT_WIDTH);
    else ow_c = OCW'(out_width_q);

    if (out_height_q == '0) oh_c = ORW'(1);
    else if (int'(out_height_q) > MAX_OUT_HEIGHT) oh_c = ORW'(MAX_OUT_HEIGHT);
    else oh_c = ORW'(out_height_q);

    if (block_w_q == '0) bw_c = BKW'(1);
    else if (int'(block_w_q) > MAX_BLOCK) bw_c = BKW'(MAX_BLOCK);
    else bw_c = BKW'(block_w_q);

    if (block_h_q == '0) bh_c = BKW'(1);
    else if (int'(block_h_q) > MAX_BLOCK) bh_c = BKW'(MAX_BLOCK);
    else bh_c = BKW'(block_h_q);
  end

  // position counters
  logic [SCW-1:0] sc_q, sc_d, sc_e, sc_inc;
  logic [BKW-1:0] cib_q, cib_d, cib_e;
  logic [OCW-1:0] oc_q, oc_d, oc_e;
  logic [BKW-1:0] rib_q, rib_d, rib_e;
  logic [ORW-1:0] or_q, or_d, or_e;

  logic last_col, last_row, in_grid, first_c, emit_c, frame_done_c;
  logic accept;

  bda_state_e state_q, state_d;
  logic       pix_ready, mem_re, mem_we, div_start, out_load, div_done;
  logic       out_valid_q;

  assign accept = pix_i.valid && pix_ready;

  always_comb begin
    sc_e  = pix_i.frame_start ? '0 : sc_q;
    cib_e = pix_i.frame_start ? '0 : cib_q;
    oc_e  = pix_i.frame_start ? '0 : oc_q;
    rib_e = pix_i.frame_start ? '0 : rib_q;
    or_e  = pix_i.frame_start ? '0 : or_q;

    last_col     = (cib_e + BKW'(1)) >= bw_c;
    last_row     = (rib_e + BKW'(1)) >= bh_c;
    in_grid      = (or_e < oh_c) && (oc_e < ow_c);
    first_c      = (rib_e == '0) && (cib_e == '0);
    emit_c       = in_grid && last_col && last_row;
    frame_done_c = (((OCW+1)'(oc_e) + (OCW+1)'(1)) == (OCW+1)'(ow_c)) &&
                   (((ORW+1)'(or_e) + (ORW+1)'(1)) == (ORW+1)'(oh_c));

    cib_d = cib_e;
    oc_d  = oc_e;
    rib_d = rib_e;
    or_d  = or_e;
    if (oc_e < ow_c) begin
      if (last_col) begin
        cib_d = '0;
        oc_d  = oc_e + OCW'(1);
      end else begin
        cib_d = cib_e + BKW'(1);
      end
    end
    sc_inc = sc_e + SCW'(1);
    sc_d   = sc_inc;
    if (sc_inc >= sw_c) begin
      sc_d  = '0;
      cib_d = '0;
      oc_d  = '0;
      if (last_row) begin
        rib_d = '0;
        if (or_e < oh_c) or_d = or_e + ORW'(1);
      end else begin
        rib_d = rib_e + BKW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q  <= '0;
      cib_q <= '0;
      oc_q  <= '0;
      rib_q <= '0;
      or_q  <= '0;
    end else if (accept) begin
      sc_q  <= sc_d;
      cib_q <= cib_d;
      oc_q  <= oc_d;
      rib_q <= rib_d;
      or_q  <= or_d;
    end
  end

  // beat captured for the read-modify-write
  logic [LANES-1:0][PIX_W-1:0] px_c, px_q;
  logic [AW-1:0]               addr_q;
  logic                        first_q, emit_q, fd_q;
  logic [OUT_X_W-1:0]          ox_q;
  logic [OUT_Y_W-1:0]          oy_q;

  assign px_c[0] = pix_i.red_in;
  assign px_c[1] = pix_i.green_in;
  assign px_c[2] = pix_i.blue_in;
  assign px_c[3] = pix_i.alpha_in;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= px_c;
      addr_q  <= oc_e[AW-1:0];
      first_q <= first_c;
      emit_q  <= emit_c;
      fd_q    <= frame_done_c;
      ox_q    <= OUT_X_W'(oc_e);
      oy_q    <= OUT_Y_W'(or_e);
    end
  end

  // column sum memory
  logic [LANES-1:0][SUMW-1:0] sum_mem [MAX_OUT_WIDTH];
  logic [LANES-1:0][SUMW-1:0] rdata_q, sum_new;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_new[l] = first_q ? SUMW'(px_q[l]) : rdata_q[l] + SUMW'(px_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) sum_mem[addr_q] <= sum_new;
    if (mem_re) rdata_q <= sum_mem[oc_e[AW-1:0]];
  end

  // divider
  logic [NW-1:0]              block_n;
  logic [LANES-1:0][SUMW-1:0] quot;

  assign block_n = NW'(bw_c) * NW'(bh_c);

  bda_div #(
    .SUMW (SUMW),
    .NW   (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (block_n),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && in_grid) state_d = ST_UPDATE;
      ST_UPDATE: state_d = emit_q ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (div_done) state_d = ST_EMIT;
      ST_EMIT:   if (!out_valid_q || avg_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pix_ready = (state_q == ST_IDLE);
    mem_re    = (state_q == ST_IDLE) && pix_i.valid && in_grid;
    mem_we    = (state_q == ST_UPDATE);
    div_start = (state_q == ST_UPDATE) && emit_q;
    out_load  = (state_q == ST_EMIT) && (!out_valid_q || avg_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic [LANES-1:0][PIX_W-1:0] avg_q;
  logic [OUT_X_W-1:0]          out_x_q;
  logic [OUT_Y_W-1:0]          out_y_q;
  logic                        out_fd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (avg_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int l = 0; l < LANES; l++) begin
        avg_q[l] <= (quot[l] > SUMW'(PIX_MAX)) ? PIX_MAX : quot[l][PIX_W-1:0];
      end
      out_x_q  <= ox_q;
      out_y_q  <= oy_q;
      out_fd_q <= fd_q;
    end
  end

  assign pix_i.ready      = pix_ready;
  assign avg_o.valid      = out_valid_q;
  assign avg_o.red_avg    = avg_q[0];
  assign avg_o.green_avg  = avg_q[1];
  assign avg_o.blue_avg   = avg_q[2];
  assign avg_o.alpha_avg  = avg_q[3];
  assign avg_o.out_x      = out_x_q;
  assign avg_o.out_y      = out_y_q;
  assign avg_o.frame_done = out_fd_q;

endmodule
